// ----- rtl/lav_pkg.sv -----
// Package for the look-at view matrix block: payload types, pipeline
// stage records and fixed-point helpers for lav_norm and the top module.
// No dependencies.
package lav_pkg;

   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 17;
   localparam int NORM_LAT   = SQRT_STEPS + DIV_STEPS + 4;

   localparam logic [31:0] FX_ONE = 32'h0001_0000;

   typedef logic [31:0]        fx_type;
   typedef fx_type [2:0]       vec_type;
   typedef fx_type [3:0]       grp_type;
   typedef grp_type [3:0]      mat_type;
   typedef logic [2:0] [31:0]  mag3_type;

   typedef struct packed {
      logic [63:0] n;
      logic [63:0] res;
      mag3_type    mag;
      logic [2:0]  neg;
   } sq_type;

   typedef struct packed {
      logic [31:0]        len;
      logic [2:0] [47:0]  rem;
      logic [2:0] [16:0]  quo;
      logic [2:0]         neg;
   } dv_type;

   // One digit of the integer square root.
   function automatic sq_type sqrt_step(sq_type s, int k);
      logic [63:0] bitv;
      logic [63:0] trial;
      sq_type      r;
      bitv  = 64'd1 << (62 - 2 * k);
      trial = s.res + bitv;
      r     = s;
      if (s.n >= trial) begin
         r.n   = s.n - trial;
         r.res = (s.res >> 1) + bitv;
      end else begin
         r.res = s.res >> 1;
      end
      return r;
   endfunction

   // One quotient bit of the three divisions by the length.
   function automatic dv_type div_step(dv_type d, int j);
      logic [47:0] dd;
      dv_type      r;
      dd = 48'(d.len) << j;
      r  = d;
      for (int c = 0; c < 3; c++) begin
         if (d.rem[c] >= dd) begin
            r.rem[c]    = d.rem[c] - dd;
            r.quo[c][j] = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic fx_type sat33(logic signed [32:0] x);
      fx_type r;
      if (x > 33'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (x < -33'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   // Cross product term: divide by 2^16 toward zero; result stays small.
   function automatic fx_type cross_fin(logic signed [36:0] x);
      logic signed [36:0] t;
      t = x[36] ? x + 37'sd65535 : x;
      return 32'(t >>> 16);
   endfunction

   // Dot product: divide by 2^16 toward zero, optional negate, saturate.
   function automatic fx_type dot_fin(logic signed [51:0] x, logic negate);
      logic signed [51:0] t;
      logic signed [52:0] q;
      fx_type             r;
      t = x[51] ? x + 52'sd65535 : x;
      q = 53'(t >>> 16);
      if (negate) begin
         q = -q;
      end
      if (q > 53'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (q < -53'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = q[31:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/lav_req_if.sv -----
// Input channel of the look-at view matrix block: eye, target and up vectors.
// No dependencies.
interface lav_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] eye_x;
   logic [31:0] eye_y;
   logic [31:0] eye_z;
   logic [31:0] target_x;
   logic [31:0] target_y;
   logic [31:0] target_z;
   logic [31:0] up_x;
   logic [31:0] up_y;
   logic [31:0] up_z;

   modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                   up_x, up_y, up_z, input ready);
   modport sink (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                 up_x, up_y, up_z, output ready);
endinterface

// ----- rtl/lav_rsp_if.sv -----
// Result channel of the look-at view matrix block: one matrix group per
// transaction. No dependencies.
interface lav_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  row_index;
   logic [31:0] val_a;
   logic [31:0] val_b;
   logic [31:0] val_c;
   logic [31:0] val_d;
   logic        final_row;

   modport source (output valid, row_index, val_a, val_b, val_c, val_d, final_row,
                   input ready);
   modport sink (input valid, row_index, val_a, val_b, val_c, val_d, final_row,
                 output ready);
endinterface

// ----- rtl/lav_norm.sv -----
// Pipelined 3-vector normalize: squares, sum, bit-per-stage square root,
// bit-per-stage division by the length. Depends on lav_pkg.
module lav_norm (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  lav_pkg::vec_type in_vec,
   output logic             out_valid,
   output lav_pkg::vec_type out_vec
);

   logic [lav_pkg::NORM_LAT-1:0] vld_ff;

   lav_pkg::mag3_type mag_in;
   logic [2:0]        neg_in;

   lav_pkg::mag3_type  mag0_ff;
   logic [2:0]         neg0_ff;
   logic [2:0] [63:0]  sqr0_ff;

   lav_pkg::sq_type sq_ff [lav_pkg::SQRT_STEPS+1];
   lav_pkg::dv_type dv_ff [lav_pkg::DIV_STEPS+1];
   lav_pkg::vec_type out_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         neg_in[c] = in_vec[c][31];
         mag_in[c] = neg_in[c] ? 32'(-in_vec[c]) : in_vec[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[lav_pkg::NORM_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag0_ff <= mag_in;
         neg0_ff <= neg_in;
         for (int c = 0; c < 3; c++) begin
            sqr0_ff[c] <= 64'(mag_in[c]) * 64'(mag_in[c]);
         end

         sq_ff[0].n   <= sqr0_ff[0] + sqr0_ff[1] + sqr0_ff[2];
         sq_ff[0].res <= '0;
         sq_ff[0].mag <= mag0_ff;
         sq_ff[0].neg <= neg0_ff;
         for (int i = 0; i < lav_pkg::SQRT_STEPS; i++) begin
            sq_ff[i+1] <= lav_pkg::sqrt_step(sq_ff[i], i);
         end

         dv_ff[0].len <= sq_ff[lav_pkg::SQRT_STEPS].res[31:0];
         dv_ff[0].neg <= sq_ff[lav_pkg::SQRT_STEPS].neg;
         dv_ff[0].quo <= '0;
         for (int c = 0; c < 3; c++) begin
            dv_ff[0].rem[c] <= {sq_ff[lav_pkg::SQRT_STEPS].mag[c], 16'h0000};
         end
         for (int i = 0; i < lav_pkg::DIV_STEPS; i++) begin
            dv_ff[i+1] <= lav_pkg::div_step(dv_ff[i], lav_pkg::DIV_STEPS - 1 - i);
         end

         for (int c = 0; c < 3; c++) begin
            if (dv_ff[lav_pkg::DIV_STEPS].len == 32'd0) begin
               out_ff[c] <= '0;
            end else if (dv_ff[lav_pkg::DIV_STEPS].neg[c]) begin
               out_ff[c] <= 32'(-dv_ff[lav_pkg::DIV_STEPS].quo[c]);
            end else begin
               out_ff[c] <= 32'(dv_ff[lav_pkg::DIV_STEPS].quo[c]);
            end
         end
      end
   end

   assign out_valid = vld_ff[lav_pkg::NORM_LAT-1];
   assign out_vec   = out_ff;

endmodule

// ----- rtl/look_at_view_matrix.sv -----
// Look-at view matrix, Q16.16. The four result groups of a request follow
// each other, one per accepted response transaction. Sustained throughput
// is set by the four result transactions per request; the pipeline itself
// takes one request per cycle until the output buffer holds it back.
// Reset (synchronous) clears all valid bits; no payload is cleared.
// Depends on lav_pkg, lav_req_if, lav_rsp_if and lav_norm.
module look_at_view_matrix (
   input  logic   clock,
   input  logic   reset,
   lav_req_if.sink   req_chan,
   lav_rsp_if.source rsp_chan
);

   logic en;

   // input stage
   logic             v0_ff;
   lav_pkg::vec_type eye0_ff, dif0_ff, up0_ff;

   // first normalize pair
   logic             fa_valid, ua_valid;
   lav_pkg::vec_type fa_vec, ua_vec;
   lav_pkg::vec_type eye_a_ff [lav_pkg::NORM_LAT];

   // cross f x up
   logic                     vc1_ff, vc2_ff;
   logic signed [5:0] [35:0] pc_ff;
   lav_pkg::vec_type         fc1_ff, eyec1_ff, fc2_ff, eyec2_ff, sraw_ff;

   // second normalize
   logic             sb_valid;
   lav_pkg::vec_type sb_vec;
   lav_pkg::vec_type f_b_ff [lav_pkg::NORM_LAT];
   lav_pkg::vec_type eye_b_ff [lav_pkg::NORM_LAT];

   // cross s x f
   logic                     vu1_ff, vu2_ff;
   logic signed [5:0] [35:0] pu_ff;
   lav_pkg::vec_type         su1_ff, fu1_ff, eyeu1_ff;
   lav_pkg::vec_type         su2_ff, fu2_ff, eyeu2_ff, uu2_ff;

   // dot products; u components reach +-2.0
   logic                     vd1_ff, vd2_ff;
   logic signed [8:0] [50:0] pd_ff;
   lav_pkg::vec_type         sd1_ff, ud1_ff, fd1_ff;
   lav_pkg::mat_type         mat_in, mat_ff;

   // output buffer
   logic             obuf_valid_ff, obuf_valid_in;
   logic [1:0]       cnt_ff, cnt_in;
   lav_pkg::mat_type obuf_ff;
   logic             obuf_free, rsp_fire;

   assign rsp_fire  = rsp_chan.valid & rsp_chan.ready;
   assign obuf_free = !obuf_valid_ff || (rsp_chan.ready && cnt_ff == 2'd3);
   assign en        = !vd2_ff || obuf_free;
   assign req_chan.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff  <= 1'b0;
         vc1_ff <= 1'b0;
         vc2_ff <= 1'b0;
         vu1_ff <= 1'b0;
         vu2_ff <= 1'b0;
         vd1_ff <= 1'b0;
         vd2_ff <= 1'b0;
      end else if (en) begin
         v0_ff  <= req_chan.valid;
         vc1_ff <= fa_valid & ua_valid;
         vc2_ff <= vc1_ff;
         vu1_ff <= sb_valid;
         vu2_ff <= vu1_ff;
         vd1_ff <= vu2_ff;
         vd2_ff <= vd1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         eye0_ff <= {req_chan.eye_z, req_chan.eye_y, req_chan.eye_x};
         up0_ff  <= {req_chan.up_z, req_chan.up_y, req_chan.up_x};
         dif0_ff[0] <= lav_pkg::sat33(33'($signed(req_chan.target_x))
                                      - 33'($signed(req_chan.eye_x)));
         dif0_ff[1] <= lav_pkg::sat33(33'($signed(req_chan.target_y))
                                      - 33'($signed(req_chan.eye_y)));
         dif0_ff[2] <= lav_pkg::sat33(33'($signed(req_chan.target_z))
                                      - 33'($signed(req_chan.eye_z)));
      end
   end

   lav_norm u_norm_f (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v0_ff),
      .in_vec    (dif0_ff),
      .out_valid (fa_valid),
      .out_vec   (fa_vec)
   );

   lav_norm u_norm_up (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v0_ff),
      .in_vec    (up0_ff),
      .out_valid (ua_valid),
      .out_vec   (ua_vec)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         eye_a_ff[0] <= eye0_ff;
         for (int i = 1; i < lav_pkg::NORM_LAT; i++) begin
            eye_a_ff[i] <= eye_a_ff[i-1];
         end

         // s = f x up
         pc_ff[0] <= $signed(fa_vec[1][17:0]) * $signed(ua_vec[2][17:0]);
         pc_ff[1] <= $signed(fa_vec[2][17:0]) * $signed(ua_vec[1][17:0]);
         pc_ff[2] <= $signed(fa_vec[2][17:0]) * $signed(ua_vec[0][17:0]);
         pc_ff[3] <= $signed(fa_vec[0][17:0]) * $signed(ua_vec[2][17:0]);
         pc_ff[4] <= $signed(fa_vec[0][17:0]) * $signed(ua_vec[1][17:0]);
         pc_ff[5] <= $signed(fa_vec[1][17:0]) * $signed(ua_vec[0][17:0]);
         fc1_ff   <= fa_vec;
         eyec1_ff <= eye_a_ff[lav_pkg::NORM_LAT-1];

         for (int c = 0; c < 3; c++) begin
            sraw_ff[c] <= lav_pkg::cross_fin(37'($signed(pc_ff[2*c]))
                                             - 37'($signed(pc_ff[2*c+1])));
         end
         fc2_ff   <= fc1_ff;
         eyec2_ff <= eyec1_ff;

         f_b_ff[0]   <= fc2_ff;
         eye_b_ff[0] <= eyec2_ff;
         for (int i = 1; i < lav_pkg::NORM_LAT; i++) begin
            f_b_ff[i]   <= f_b_ff[i-1];
            eye_b_ff[i] <= eye_b_ff[i-1];
         end
      end
   end

   lav_norm u_norm_s (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vc2_ff),
      .in_vec    (sraw_ff),
      .out_valid (sb_valid),
      .out_vec   (sb_vec)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         // u = s x f
         pu_ff[0] <= $signed(sb_vec[1][17:0]) * $signed(f_b_ff[lav_pkg::NORM_LAT-1][2][17:0]);
         pu_ff[1] <= $signed(sb_vec[2][17:0]) * $signed(f_b_ff[lav_pkg::NORM_LAT-1][1][17:0]);
         pu_ff[2] <= $signed(sb_vec[2][17:0]) * $signed(f_b_ff[lav_pkg::NORM_LAT-1][0][17:0]);
         pu_ff[3] <= $signed(sb_vec[0][17:0]) * $signed(f_b_ff[lav_pkg::NORM_LAT-1][2][17:0]);
         pu_ff[4] <= $signed(sb_vec[0][17:0]) * $signed(f_b_ff[lav_pkg::NORM_LAT-1][1][17:0]);
         pu_ff[5] <= $signed(sb_vec[1][17:0]) * $signed(f_b_ff[lav_pkg::NORM_LAT-1][0][17:0]);
         su1_ff   <= sb_vec;
         fu1_ff   <= f_b_ff[lav_pkg::NORM_LAT-1];
         eyeu1_ff <= eye_b_ff[lav_pkg::NORM_LAT-1];

         for (int c = 0; c < 3; c++) begin
            uu2_ff[c] <= lav_pkg::cross_fin(37'($signed(pu_ff[2*c]))
                                            - 37'($signed(pu_ff[2*c+1])));
         end
         su2_ff   <= su1_ff;
         fu2_ff   <= fu1_ff;
         eyeu2_ff <= eyeu1_ff;

         for (int c = 0; c < 3; c++) begin
            pd_ff[c]   <= $signed(su2_ff[c][17:0]) * $signed(eyeu2_ff[c]);
            pd_ff[3+c] <= $signed(uu2_ff[c][18:0]) * $signed(eyeu2_ff[c]);
            pd_ff[6+c] <= $signed(fu2_ff[c][17:0]) * $signed(eyeu2_ff[c]);
         end
         sd1_ff <= su2_ff;
         ud1_ff <= uu2_ff;
         fd1_ff <= fu2_ff;

         mat_ff <= mat_in;
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mat_in[k][0] = sd1_ff[k];
         mat_in[k][1] = ud1_ff[k];
         mat_in[k][2] = 32'(-fd1_ff[k]);
         mat_in[k][3] = '0;
      end
      mat_in[3][0] = lav_pkg::dot_fin(52'($signed(pd_ff[0])) + 52'($signed(pd_ff[1]))
                                      + 52'($signed(pd_ff[2])), 1'b1);
      mat_in[3][1] = lav_pkg::dot_fin(52'($signed(pd_ff[3])) + 52'($signed(pd_ff[4]))
                                      + 52'($signed(pd_ff[5])), 1'b1);
      mat_in[3][2] = lav_pkg::dot_fin(52'($signed(pd_ff[6])) + 52'($signed(pd_ff[7]))
                                      + 52'($signed(pd_ff[8])), 1'b0);
      mat_in[3][3] = lav_pkg::FX_ONE;
   end

   always_comb begin
      obuf_valid_in = obuf_valid_ff;
      cnt_in        = cnt_ff;
      if (vd2_ff && obuf_free) begin
         obuf_valid_in = 1'b1;
         cnt_in        = 2'd0;
      end else if (rsp_fire) begin
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            obuf_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         obuf_valid_ff <= 1'b0;
         cnt_ff        <= 2'd0;
      end else begin
         obuf_valid_ff <= obuf_valid_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (vd2_ff && obuf_free) begin
         obuf_ff <= mat_ff;
      end
   end

   assign rsp_chan.valid     = obuf_valid_ff;
   assign rsp_chan.row_index = cnt_ff;
   assign rsp_chan.val_a     = obuf_ff[cnt_ff][0];
   assign rsp_chan.val_b     = obuf_ff[cnt_ff][1];
   assign rsp_chan.val_c     = obuf_ff[cnt_ff][2];
   assign rsp_chan.val_d     = obuf_ff[cnt_ff][3];
   assign rsp_chan.final_row = (cnt_ff == 2'd3);

endmodule
